// ===== rtl/core/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table core.
// Holds table geometry, opcode and status codes, the slot row layout and
// the controller/datapath command and status structs. No dependencies.
package oaht_pkg;

	// Table geometry; SLOTS must be a power of two (home slot = low hash bits)
	localparam int SLOTS      = 256;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int VALUE_BITS = 64;
	localparam int KEY_W      = 32;
	localparam int LOAD_LIMIT = 3 * SLOTS;
	localparam int LOAD_W     = CNT_W + 3;

	// Stream word layout
	localparam int IN_BITS  = 2 + KEY_W + 32 + 64;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 + 1 + 64;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Request opcodes
	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_SET = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	// Response status codes
	localparam logic [1:0] RS_DONE     = 2'd0;
	localparam logic [1:0] RS_NOTFOUND = 2'd1;
	localparam logic [1:0] RS_FULL     = 2'd2;

	// Slot status codes
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_LIVE  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]            status;
		logic [KEY_W-1:0]      key;
		logic [VALUE_BITS-1:0] value;
	} slot_row_t;

	typedef struct packed {
		logic       load;       // latch request, start probe at home slot
		logic       advance;    // step to the next slot
		logic       wr_en;      // write the slot row
		logic       wr_free;    // write at the first free slot, not the probe slot
		logic       wr_tomb;    // write a tombstone over the probe slot
		logic       inc_used;   // count one more occupied slot
		logic       res_load;   // capture a response
		logic [1:0] res_status;
		logic       res_new;
		logic       res_hit;    // return the probed slot's value
		logic       out_load;   // move response into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       used_zero;
		logic       slot_empty;
		logic       slot_tomb;
		logic       key_match;
		logic       last;
		logic       free_ok;
		logic       out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/oaht_dp.sv =====
// Datapath of the hash table core: slot memory, valid bits, probe pointer,
// tombstone tracker, occupancy count, response and output registers.
// Depends on oaht_pkg; driven by oaht_ctrl through dp_cmd_t.
module oaht_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  oaht_pkg::dp_cmd_t        cmd,
	output oaht_pkg::dp_sts_t        sts,
	input  logic [1:0]               in_op,
	input  logic [31:0]              in_key,
	input  logic [31:0]              in_hash,
	input  logic [63:0]              in_value,
	input  logic                     m_ready,
	output logic                     m_valid,
	output logic [oaht_pkg::OUT_W-1:0] m_data
);
	import oaht_pkg::*;

	slot_row_t mem [SLOTS];
	logic [SLOTS-1:0] vld_q;

	logic [1:0]            op_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      tomb_q;
	logic                  tomb_seen_q;
	logic [CNT_W-1:0]      used_q;

	slot_row_t             rd_q;
	logic                  rd_vld_q;

	logic [1:0]            res_status_q;
	logic                  res_new_q;
	logic [63:0]           res_val_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      wr_addr;
	logic [IDX_W-1:0]      free_idx;
	slot_row_t             wr_row;
	logic [1:0]            slot_st;
	logic [LOAD_W-1:0]     load_need;

	assign rd_addr  = cmd.load ? in_hash[IDX_W-1:0] : pos_q + 1'b1;
	assign free_idx = tomb_seen_q ? tomb_q : pos_q;
	assign wr_addr  = cmd.wr_free ? free_idx : pos_q;
	assign slot_st  = rd_vld_q ? rd_q.status : SLOT_EMPTY;

	always_comb begin
		if (cmd.wr_tomb) begin
			wr_row = rd_q;
			wr_row.status = SLOT_TOMB;
		end else begin
			wr_row.status = SLOT_LIVE;
			wr_row.key    = key_q;
			wr_row.value  = value_q;
		end
	end

	// Reject a set when 4 * (used + 1) exceeds three times the slot count
	assign load_need = (LOAD_W'(used_q) + 1'b1) << 2;

	always_comb begin
		sts.op         = op_q;
		sts.full       = load_need > LOAD_W'(LOAD_LIMIT);
		sts.used_zero  = used_q == '0;
		sts.slot_empty = slot_st == SLOT_EMPTY;
		sts.slot_tomb  = slot_st == SLOT_TOMB;
		sts.key_match  = (slot_st == SLOT_LIVE) && (rd_q.key == key_q);
		sts.last       = cnt_q == IDX_W'(SLOTS - 1);
		sts.free_ok    = tomb_seen_q || (slot_st == SLOT_TOMB);
		sts.out_free   = !out_valid_q || m_ready;
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// Request and probe state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			key_q   <= in_key;
			value_q <= in_value[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cnt_q       <= '0;
			tomb_q      <= '0;
			tomb_seen_q <= 1'b0;
			used_q      <= '0;
		end else begin
			if (cmd.load) begin
				pos_q       <= in_hash[IDX_W-1:0];
				cnt_q       <= '0;
				tomb_seen_q <= 1'b0;
			end else if (cmd.advance) begin
				pos_q <= pos_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
				if (sts.slot_tomb && !tomb_seen_q) begin
					tomb_q      <= pos_q;
					tomb_seen_q <= 1'b1;
				end
			end
			if (cmd.inc_used) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	// Response capture and output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_new_q    <= cmd.res_new;
			res_val_q    <= cmd.res_hit ? 64'(rd_q.value) : '0;
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_W'({res_val_q, res_new_q, res_status_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = out_data_q;

endmodule

// ===== rtl/core/oaht_ctrl.sv =====
// Controller of the hash table core: accept, probe and respond sequencer.
// Depends on oaht_pkg; commands oaht_dp and reads its status struct.
module oaht_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_op,
	input  oaht_pkg::dp_sts_t    sts,
	output oaht_pkg::dp_cmd_t    cmd
);
	import oaht_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_RESP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_op)
						OP_SET: begin
							if (sts.full) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = RS_FULL;
								state_d        = ST_RESP;
							end else begin
								state_d = ST_PROBE;
							end
						end
						OP_GET, OP_DEL: begin
							if (sts.used_zero) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = RS_NOTFOUND;
								state_d        = ST_RESP;
							end else begin
								state_d = ST_PROBE;
							end
						end
						default: begin
							cmd.res_load   = 1'b1;
							cmd.res_status = RS_NOTFOUND;
							state_d        = ST_RESP;
						end
					endcase
				end
			end
			ST_PROBE: begin
				if (sts.slot_empty) begin
					// Chain ends: set claims the first free slot, others miss
					cmd.res_load = 1'b1;
					state_d      = ST_RESP;
					if (sts.op == OP_SET) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_free    = 1'b1;
						cmd.inc_used   = !sts.free_ok;
						cmd.res_status = RS_DONE;
						cmd.res_new    = 1'b1;
					end else begin
						cmd.res_status = RS_NOTFOUND;
					end
				end else if (sts.key_match) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = RS_DONE;
					state_d        = ST_RESP;
					case (sts.op)
						OP_SET: cmd.wr_en = 1'b1;
						OP_DEL: begin
							cmd.wr_en   = 1'b1;
							cmd.wr_tomb = 1'b1;
						end
						default: cmd.res_hit = 1'b1;
					endcase
				end else if (sts.last) begin
					// Whole table visited without an empty slot
					cmd.res_load = 1'b1;
					state_d      = ST_RESP;
					if (sts.op == OP_SET && sts.free_ok) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_free    = 1'b1;
						cmd.res_status = RS_DONE;
						cmd.res_new    = 1'b1;
					end else if (sts.op == OP_SET) begin
						cmd.res_status = RS_FULL;
					end else begin
						cmd.res_status = RS_NOTFOUND;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/open_addressing_hash_table_core.sv =====
// Linear-probing key/value hash table with tombstones, 256 slots of a
// 32-bit key and a 64-bit value. One request word in, one response word
// out. A request is accepted, then the probe visits one slot a cycle (the
// slot memory has a single registered read port) and walks at most the
// whole table, then the response is handed to the output register. A set
// refused by the three-quarter load limit, a get or delete on an empty
// table and a request with an unknown opcode skip probing. The hand-off is
// held for as long as the sink leaves the previous response word untaken.
// The next request is taken once the response sits in the output register,
// even if the sink has not taken it.
// The table needs no clearing pass: a flip-flop valid bit per slot, cleared
// by reset, makes every never-written slot read as empty. Deleted slots
// stay as tombstones and still count toward the load limit; there is no
// rehash. Depends on oaht_pkg, oaht_ctrl and oaht_dp.
module open_addressing_hash_table_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// opcode[1:0], key_id[33:2], key_hash[65:34], write_value[129:66], zero pad
	input  logic [oaht_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], is_new[2], read_value[66:3], zero pad
	output logic [oaht_pkg::OUT_W-1:0]    m_tdata
);
	import oaht_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [1:0]  in_op;
	logic [31:0] in_key;
	logic [31:0] in_hash;
	logic [63:0] in_value;

	// Unpack the request word
	assign in_op    = s_tdata[1:0];
	assign in_key   = s_tdata[33:2];
	assign in_hash  = s_tdata[65:34];
	assign in_value = s_tdata[129:66];

	// Sequencer: accept, walk the probe chain, hand off the response
	oaht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (in_op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot store, probe pointer, occupancy and output register
	oaht_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_op    (in_op),
		.in_key   (in_key),
		.in_hash  (in_hash),
		.in_value (in_value),
		.m_ready  (m_tready),
		.m_valid  (m_tvalid),
		.m_data   (m_tdata)
	);

`ifndef NO_ASSERTIONS
	// Never overwrite a response word the sink has not taken
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("response loaded over an untaken word");

	// A slot newly counted as occupied must respect the load limit
	a_inc_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc_used |-> (cmd.wr_en && !cmd.wr_tomb && !sts.full))
		else $error("occupancy grew past the load limit");

	// A request is latched only on an accepted word
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (s_tvalid && s_tready))
		else $error("request latched without a handshake");

	// Table writes never coincide with accepting a new request
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !s_tready)
		else $error("slot write while idle");
`endif

endmodule
